/* rtl/bbr_pkg.sv */
`default_nettype none

package bbr_pkg;

  // Geometry limits and derived widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFGW_W     = 11;
  localparam int CFGH_W     = 13;
  localparam int WCMP_W     = (COL_W + 1 > CFGW_W) ? COL_W + 1 : CFGW_W;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFGW_W-1:0] WIDTH_RESET  = CFGW_W'(640);
  localparam logic [CFGH_W-1:0] HEIGHT_RESET = CFGH_W'(480);

  // Pixel and sum widths
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int SUM_W = 12;

  // Reciprocals for rounded division by 6 and 9
  localparam int RECIP6 = 10923;
  localparam int RECIP9 = 7282;
  localparam int PROD_W = SUM_W + 15;

  // Queue between window stage and output stage
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic {
    OP_PIX,
    OP_DRAIN
  } op_e;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_e;

  // Classified item handed from the front to the window stage
  typedef struct packed {
    op_e              kind;
    logic [COL_W-1:0] addr;
    logic             first_col;
    logic             col_ge2;
    logic             row_ge1;
    logic             row_ge2;
    logic             row_end;
    logic [PIX_W-1:0] pix;
  } op_t;

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;
  typedef logic [2:0][2:0][CH_W-1:0]  chan_win_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    div_e                  div;
    logic                  done;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    res_t a;
    res_t b;
  } entry_t;

  // Sum one channel over the selected rows and columns
  function automatic logic [SUM_W-1:0] win_sum(input chan_win_t ch, input logic [2:0] rows,
                                               input logic [2:0] cols);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rows[r] && cols[c]) begin
          s = s + SUM_W'(ch[r][c]);
        end
      end
    end
    return s;
  endfunction

  // Pick the divisor from the row and column masks (two or three bits each)
  function automatic div_e div_sel(input logic [2:0] rows, input logic [2:0] cols);
    div_e d;
    if ((&rows) && (&cols)) begin
      d = DIV_9;
    end else if ((&rows) || (&cols)) begin
      d = DIV_6;
    end else begin
      d = DIV_4;
    end
    return d;
  endfunction

  // Mean rounded half up: floor((2*s + n) / (2*n))
  function automatic logic [CH_W-1:0] box_avg(input logic [SUM_W-1:0] s, input div_e d);
    logic [SUM_W:0]    x4;
    logic [SUM_W:0]    x6;
    logic [SUM_W+1:0]  x9;
    logic [PROD_W-1:0] p6;
    logic [PROD_W-1:0] p9;
    logic [CH_W-1:0]   v;
    x4 = {1'b0, s} + (SUM_W+1)'(2);
    x6 = {1'b0, s} + (SUM_W+1)'(3);
    x9 = {1'b0, s, 1'b0} + (SUM_W+2)'(9);
    p6 = PROD_W'(x6) * PROD_W'(RECIP6);
    p9 = PROD_W'(x9) * PROD_W'(RECIP9);
    case (d)
      DIV_4:   v = x4[CH_W+1:2];
      DIV_6:   v = p6[CH_W+15:16];
      DIV_9:   v = p9[CH_W+16:17];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/bbr_ram.sv */
`default_nettype none

module bbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port, registered read returning old data on collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/bbr_front.sv */
`default_nettype none

module bbr_front
  import bbr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic [CH_W-1:0]       in_red_i,
  input  wire logic [CH_W-1:0]       in_green_i,
  input  wire logic [CH_W-1:0]       in_blue_i,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [FIFO_CNT_W-1:0] fifo_count_i,
  output logic [COL_W-1:0]           rd_addr_o,
  output logic                       nwr_en_o,
  output logic [PIX_W-1:0]           nwr_data_o,
  output logic                       op_valid_o,
  output op_t                        op_o
);

  logic [CFGW_W-1:0] width_q;
  logic [CFGH_W-1:0] height_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  drain_q;
  logic              draining_q;
  logic              op_valid_q;
  op_t               op_q;

  logic [WCMP_W-1:0]     w_raw;
  logic [WCMP_W-1:0]     eff_w;
  logic [WCMP_W-1:0]     last_col;
  logic [CFGH_W-1:0]     eff_h;
  logic [CFGH_W-1:0]     last_row;
  logic [FIFO_CNT_W:0]   used;
  logic                  accept;
  logic                  is_drain;
  logic                  end_row;
  logic                  end_frame;
  logic                  drain_end;
  logic                  op_valid_d;
  op_t                   op_d;

  // Clamp the frame geometry
  always_comb begin
    w_raw    = WCMP_W'(width_q);
    if (w_raw < WCMP_W'(2)) begin
      eff_w = WCMP_W'(2);
    end else if (w_raw > WCMP_W'(MAX_WIDTH)) begin
      eff_w = WCMP_W'(MAX_WIDTH);
    end else begin
      eff_w = w_raw;
    end
    if (height_q < CFGH_W'(2)) begin
      eff_h = CFGH_W'(2);
    end else if (height_q > CFGH_W'(MAX_HEIGHT)) begin
      eff_h = CFGH_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
    last_col = eff_w - WCMP_W'(1);
    last_row = eff_h - CFGH_W'(1);
  end

  // Hold input while queue plus in-flight item could overflow
  assign used       = {1'b0, fifo_count_i} + {{FIFO_CNT_W{1'b0}}, op_valid_q};
  assign in_stall_o = (used >= (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the item
  always_comb begin
    is_drain  = (req_type_i == REQ_DRAIN);
    end_row   = WCMP_W'(col_q) >= last_col;
    end_frame = CFGH_W'(row_q) >= last_row;
    drain_end = WCMP_W'(drain_q) >= last_col;

    rd_addr_o = is_drain ? (drain_q + COL_W'(1)) : col_q;

    op_valid_d = accept && (is_drain == draining_q);

    op_d.kind      = is_drain ? OP_DRAIN : OP_PIX;
    op_d.addr      = rd_addr_o;
    op_d.first_col = is_drain ? (drain_q == '0) : (col_q == '0);
    op_d.col_ge2   = col_q >= COL_W'(2);
    op_d.row_ge1   = row_q != '0;
    op_d.row_ge2   = row_q >= ROW_W'(2);
    op_d.row_end   = is_drain ? drain_end : end_row;
    op_d.pix       = {in_red_i, in_green_i, in_blue_i};

    nwr_en_o   = accept && !is_drain && !draining_q;
    nwr_data_o = op_d.pix;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[CFGW_W-1:0];
        CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i[CFGH_W-1:0];
        default:          width_q  <= width_q;
      endcase
    end
  end

  // Advance position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      drain_q    <= '0;
      draining_q <= 1'b0;
      op_valid_q <= 1'b0;
    end else begin
      op_valid_q <= op_valid_d;
      if (op_valid_d) begin
        if (is_drain) begin
          if (drain_end) begin
            draining_q <= 1'b0;
            drain_q    <= '0;
            row_q      <= '0;
            col_q      <= '0;
          end else begin
            drain_q <= drain_q + COL_W'(1);
          end
        end else if (end_row) begin
          col_q <= '0;
          if (end_frame) begin
            draining_q <= 1'b1;
            drain_q    <= '0;
            row_q      <= '0;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // Stage register aligned with the line store read data
  always_ff @(posedge clk_i) begin
    if (op_valid_d) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = op_valid_q;
  assign op_o       = op_q;

endmodule

`default_nettype wire

/* rtl/bbr_window.sv */
`default_nettype none

module bbr_window
  import bbr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             op_valid_i,
  input  wire op_t              op_i,
  input  wire logic [PIX_W-1:0] older_rdata_i,
  input  wire logic [PIX_W-1:0] newer_rdata_i,
  output logic                  owr_en_o,
  output logic [COL_W-1:0]      owr_addr_o,
  output logic [PIX_W-1:0]      owr_data_o,
  output logic                  push_o,
  output entry_t                entry_o
);

  win_t                    win_q;
  logic [1:0][PIX_W-1:0]   col0_q;
  logic                    fwd_valid_q;
  logic [COL_W-1:0]        fwd_addr_q;
  logic [PIX_W-1:0]        fwd_data_q;

  win_t                    win_d;
  logic [2:0][PIX_W-1:0]   ncol;
  logic [PIX_W-1:0]        older_v;
  logic                    is_pix;
  logic [2:0]              rows_a;
  logic [2:0]              cols_a;
  logic [2:0]              cols_b;
  chan_win_t [2:0]         chw;

  always_comb begin
    is_pix = (op_i.kind == OP_PIX);

    // Forward an older-row write that landed on the same edge as this read
    older_v = (fwd_valid_q && (fwd_addr_q == op_i.addr)) ? fwd_data_q : older_rdata_i;
    ncol[0] = older_v;
    ncol[1] = newer_rdata_i;
    ncol[2] = op_i.pix;

    // Shift the window; first drain column comes from the saved left edge
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
      win_d[r][2] = ncol[r];
    end
    if (!is_pix && op_i.first_col) begin
      win_d[0][1] = col0_q[0];
      win_d[1][1] = col0_q[1];
    end

    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          chw[k][r][c] = win_d[r][c][PIX_W-1-CH_W*k -: CH_W];
        end
      end
    end

    // Clip the neighborhood to the frame
    if (is_pix) begin
      rows_a = op_i.row_ge2 ? 3'b111 : 3'b110;
      cols_a = op_i.col_ge2 ? 3'b111 : 3'b110;
    end else begin
      rows_a = 3'b011;
      cols_a = {!op_i.row_end, 1'b1, !op_i.first_col};
    end
    cols_b = 3'b110;

    entry_o.has_a  = is_pix ? (op_i.row_ge1 && !op_i.first_col) : 1'b1;
    entry_o.has_b  = is_pix && op_i.row_ge1 && op_i.row_end;
    entry_o.a.div  = div_sel(rows_a, cols_a);
    entry_o.a.done = !is_pix && op_i.row_end;
    entry_o.a.last = is_pix ? !op_i.row_end : 1'b1;
    entry_o.b.div  = div_sel(rows_a, cols_b);
    entry_o.b.done = 1'b0;
    entry_o.b.last = 1'b1;
    for (int k = 0; k < 3; k++) begin
      entry_o.a.sum[k] = win_sum(chw[k], rows_a, cols_a);
      entry_o.b.sum[k] = win_sum(chw[k], rows_a, cols_b);
    end

    push_o     = op_valid_i && (entry_o.has_a || entry_o.has_b);
    owr_en_o   = op_valid_i && is_pix;
    owr_addr_o = op_i.addr;
    owr_data_o = newer_rdata_i;
  end

  // Track the last older-row write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= owr_en_o;
    end
  end

  // Window, left-edge column and forwarding payload
  always_ff @(posedge clk_i) begin
    fwd_addr_q <= owr_addr_o;
    fwd_data_q <= owr_data_o;
    if (op_valid_i) begin
      win_q <= win_d;
      if (is_pix && op_i.first_col) begin
        col0_q[0] <= newer_rdata_i;
        col0_q[1] <= op_i.pix;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bbr_fifo.sv */
`default_nettype none

module bbr_fifo
  import bbr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire entry_t                push_data_i,
  input  wire logic                  pop_i,
  output entry_t                     head_o,
  output logic                       head_valid_o,
  output logic [FIFO_CNT_W-1:0]      count_o
);

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_q;
  logic [FIFO_AW-1:0]    rd_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign head_o       = mem_q[rd_q];
  assign head_valid_o = (count_q != '0);
  assign count_o      = count_q;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < FIFO_CNT_W'(FIFO_DEPTH))
    else $error("entry queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("entry queue underflow");

endmodule

`default_nettype wire

/* rtl/bbr_out.sv */
`default_nettype none

module bbr_out
  import bbr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire entry_t     head_i,
  input  wire logic       head_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [CH_W-1:0] out_red_o,
  output logic [CH_W-1:0] out_green_o,
  output logic [CH_W-1:0] out_blue_o,
  output logic            frame_done_o,
  output logic            run_last_o
);

  logic            sel_q;
  logic            valid_q;
  logic [CH_W-1:0] red_q;
  logic [CH_W-1:0] green_q;
  logic [CH_W-1:0] blue_q;
  logic            done_q;
  logic            last_q;

  logic take_a;
  logic final_res;
  logic load;
  res_t cur;

  // Pick the next result of the head entry
  always_comb begin
    take_a    = head_i.has_a && !sel_q;
    cur       = take_a ? head_i.a : head_i.b;
    final_res = !(take_a && head_i.has_b);
    load      = head_valid_i && (!valid_q || !out_stall_i);
    pop_o     = load && final_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      sel_q   <= !final_res;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Divide into the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= box_avg(cur.sum[0], cur.div);
      green_q <= box_avg(cur.sum[1], cur.div);
      blue_q  <= box_avg(cur.sum[2], cur.div);
      done_q  <= cur.done;
      last_q  <= cur.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_red_o    = red_q;
  assign out_green_o  = green_q;
  assign out_blue_o   = blue_q;
  assign frame_done_o = done_q;
  assign run_last_o   = last_q;

  a_split_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> head_valid_i)
    else $error("second result pending without a head entry");

  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && sel_q |-> final_res)
    else $error("second result of an entry not final");

endmodule

`default_nettype wire

/* rtl/box_blur_3x3_rgb.sv */
`default_nettype none

// Streaming 3x3 box blur of an RGB frame in raster order, clipped at the frame
// edges (mean of 4, 6 or 9 pixels, each channel rounded half up). Outputs trail
// the input by one row: a pixel item emits the pixel up and to the left, and the
// last pixel of a row also emits that row's right edge pixel. After the frame,
// send frame_width drain ticks to get the bottom row; frame_done marks its last
// pixel. The input takes one item per cycle unless stalled; the output delivers
// one result per cycle unless out_stall is high, and a four-entry queue absorbs
// the extra result of a row-end item, which gives two. An accepted item passes
// the line store read, the window and sums, the queue, then the divide into the
// output register. Line stores come up unset and need no clearing pass; users
// must write frame geometry registers between frames; the block does not check.
module box_blur_3x3_rgb
  import bbr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic [CH_W-1:0]       in_red_i,
  input  wire logic [CH_W-1:0]       in_green_i,
  input  wire logic [CH_W-1:0]       in_blue_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CH_W-1:0]            out_red_o,
  output logic [CH_W-1:0]            out_green_o,
  output logic [CH_W-1:0]            out_blue_o,
  output logic                       frame_done_o,
  output logic                       run_last_o,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [COL_W-1:0]      rd_addr;
  logic                  nwr_en;
  logic [PIX_W-1:0]      nwr_data;
  logic                  owr_en;
  logic [COL_W-1:0]      owr_addr;
  logic [PIX_W-1:0]      owr_data;
  logic [PIX_W-1:0]      older_rdata;
  logic [PIX_W-1:0]      newer_rdata;
  logic                  op_valid;
  op_t                   op;
  logic                  push;
  entry_t                push_data;
  logic                  pop;
  entry_t                head;
  logic                  head_valid;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // Accept and classify items, drive line store addresses
  bbr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_count_i (fifo_count),
    .rd_addr_o    (rd_addr),
    .nwr_en_o     (nwr_en),
    .nwr_data_o   (nwr_data),
    .op_valid_o   (op_valid),
    .op_o         (op)
  );

  // Line stores: newer row written at accept, older row in the following cycle
  bbr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (nwr_en),
    .waddr_i (rd_addr),
    .wdata_i (nwr_data),
    .raddr_i (rd_addr),
    .rdata_o (newer_rdata)
  );

  bbr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (owr_en),
    .waddr_i (owr_addr),
    .wdata_i (owr_data),
    .raddr_i (rd_addr),
    .rdata_o (older_rdata)
  );

  // Window update and clipped sums
  bbr_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_i          (op),
    .older_rdata_i (older_rdata),
    .newer_rdata_i (newer_rdata),
    .owr_en_o      (owr_en),
    .owr_addr_o    (owr_addr),
    .owr_data_o    (owr_data),
    .push_o        (push),
    .entry_o       (push_data)
  );

  bbr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .count_o      (fifo_count)
  );

  // Divide and present results
  bbr_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .frame_done_o (frame_done_o),
    .run_last_o   (run_last_o)
  );

  a_push_needs_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> op_valid)
    else $error("queue push without a window operation");

endmodule

`default_nettype wire

/* dv/bbr_checker.sv */
module bbr_checker
  import bbr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  req_type_i,
  input  logic [CH_W-1:0]       in_red_i,
  input  logic [CH_W-1:0]       in_green_i,
  input  logic [CH_W-1:0]       in_blue_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CH_W-1:0]       out_red_i,
  input  logic [CH_W-1:0]       out_green_i,
  input  logic [CH_W-1:0]       out_blue_i,
  input  logic                  frame_done_i,
  input  logic                  run_last_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    err_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            done;
    logic            last;
  } blur_px_t;

  blur_px_t       blur_q[$];
  logic [PIX_W-1:0] older_row[MAX_WIDTH];
  logic [PIX_W-1:0] newer_row[MAX_WIDTH];
  logic [PIX_W-1:0] win[3][3];
  logic [CFGW_W-1:0] width_reg;
  logic [CFGH_W-1:0] height_reg;
  int col, row, drain_col;
  bit draining;

  assign pending_o = blur_q.size();

  function automatic int clamp_width();
    int w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int clamp_height();
    int h;
    h = height_reg;
    if (h < 2) h = 2;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // Mean over the clipped neighborhood, each channel rounded half up
  function automatic blur_px_t region_mean(input logic [PIX_W-1:0] g[3][3], input int r0,
                                           input int r1, input int c0, input int c1,
                                           input logic done, input logic last);
    blur_px_t p;
    int n, s, sh;
    logic [CH_W-1:0] v[3];
    n = (r1 - r0 + 1) * (c1 - c0 + 1);
    for (int ch = 0; ch < 3; ch++) begin
      sh = 16 - 8 * ch;
      s = 0;
      for (int r = r0; r <= r1; r++)
        for (int c = c0; c <= c1; c++)
          s += (g[r][c] >> sh) & 8'hFF;
      v[ch] = CH_W'((2 * s + n) / (2 * n));
    end
    p.red = v[0];
    p.green = v[1];
    p.blue = v[2];
    p.done = done;
    p.last = last;
    return p;
  endfunction

  function automatic logic [PIX_W-1:0] row_fetch(input bit older, input int idx);
    if (idx < 0 || idx >= MAX_WIDTH) return '0;
    return older ? older_row[idx] : newer_row[idx];
  endfunction

  // Advance the blur state by one accepted transaction
  task automatic predict_blur(input logic kind, input logic [PIX_W-1:0] pix);
    logic [PIX_W-1:0] g[3][3];
    int w, c;
    bit endrow, fin;
    w = clamp_width();
    if (kind == REQ_DRAIN) begin
      if (!draining) return;
      fin = drain_col >= w - 1;
      for (int k = 0; k < 3; k++) begin
        g[0][k] = row_fetch(1, drain_col + k - 1);
        g[1][k] = row_fetch(0, drain_col + k - 1);
        g[2][k] = '0;
      end
      blur_q.push_back(region_mean(g, 0, 1, drain_col > 0 ? 0 : 1, fin ? 1 : 2, fin, 1'b1));
      if (fin) begin
        draining = 0;
        drain_col = 0;
        row = 0;
        col = 0;
      end else begin
        drain_col++;
      end
      return;
    end
    if (draining) return;
    c = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
    endrow = c >= w - 1;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = older_row[c];
    win[1][2] = newer_row[c];
    win[2][2] = pix;
    older_row[c] = newer_row[c];
    newer_row[c] = pix;
    if (row >= 1 && c >= 1)
      blur_q.push_back(region_mean(win, row >= 2 ? 0 : 1, 2, c >= 2 ? 0 : 1, 2, 1'b0, !endrow));
    if (row >= 1 && endrow)
      blur_q.push_back(region_mean(win, row >= 2 ? 0 : 1, 2, 1, 2, 1'b0, 1'b1));
    if (endrow) begin
      col = 0;
      if (row >= clamp_height() - 1) begin
        draining = 1;
        drain_col = 0;
        row = 0;
      end else begin
        row++;
      end
    end else begin
      col = c + 1;
    end
  endtask

  // Watch config writes, input and output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    blur_px_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          win[r][c] = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col = 0;
      row = 0;
      drain_col = 0;
      draining = 0;
      err_count_o = 0;
      blur_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{out_red_i, out_green_i, out_blue_i, frame_done_i, run_last_i};
        if (blur_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          err_count_o++;
        end else begin
          want = blur_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch r/g/b/done/last expected %h %h %h %b %b actual %h %h %h %b %b",
                     $time, want.red, want.green, want.blue, want.done, want.last,
                     got.red, got.green, got.blue, got.done, got.last);
            err_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_blur(req_type_i, {in_red_i, in_green_i, in_blue_i});
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) width_reg = cfg_wdata_i[CFGW_W-1:0];
        else height_reg = cfg_wdata_i[CFGH_W-1:0];
      end
    end
  end
endmodule

/* dv/tb_box_blur_3x3_rgb.sv */
module tb_box_blur_3x3_rgb;
  import bbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0, in_stall, req_type = REQ_PIXEL;
  logic [CH_W-1:0] in_red = 0, in_green = 0, in_blue = 0;
  logic out_valid, out_stall = 0;
  logic [CH_W-1:0] out_red, out_green, out_blue;
  logic frame_done, run_last;
  logic cfg_we = 0, cfg_idx = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = 0;
  int err_count, pending, cycles = 0, sent = 0;
  bit idle_on = 1, hold_req = 0, held = 0;

  always #10 clk_i = ~clk_i;

  box_blur_3x3_rgb dut (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall), .req_type_i(req_type),
    .in_red_i(in_red), .in_green_i(in_green), .in_blue_i(in_blue),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_red_o(out_red),
    .out_green_o(out_green), .out_blue_o(out_blue), .frame_done_o(frame_done),
    .run_last_o(run_last), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  bbr_checker chk (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_i(in_stall), .req_type_i(req_type),
    .in_red_i(in_red), .in_green_i(in_green), .in_blue_i(in_blue),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_red_i(out_red),
    .out_green_i(out_green), .out_blue_i(out_blue), .frame_done_i(frame_done),
    .run_last_i(run_last), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .err_count_o(err_count), .pending_o(pending)
  );

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (300) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(input logic kind, input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1;
    req_type <= kind;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  // Write a register once the block has drained
  task automatic write_reg(input logic idx, input int val);
    in_valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  function automatic logic [CH_W-1:0] chan_val(input int mode);
    case (mode)
      1: return 8'hFF;
      2: return 8'h00;
      3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return CH_W'($urandom);
    endcase
  endfunction

  // Stream one frame plus its drain ticks, with stray transactions mixed in
  task automatic run_frame(input int w, input int h, input int noise, input int mode);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < noise)
        send_item(REQ_DRAIN, chan_val(0), chan_val(0), chan_val(0));
      send_item(REQ_PIXEL, chan_val(mode), chan_val(mode), chan_val(mode));
    end
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(0, 99) < noise)
        send_item(REQ_PIXEL, chan_val(0), chan_val(0), chan_val(0));
      send_item(REQ_DRAIN, chan_val(0), chan_val(0), chan_val(0));
    end
  endtask

  initial begin
    int w, h, lim;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: smallest frames, saturated channels, stray ticks
    write_reg(CFG_FRAME_WIDTH, 2);
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_item(REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    run_frame(2, 2, 0, 1);
    run_frame(2, 2, 0, 2);
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    run_frame(3, 3, 20, 3);

    // Out-of-range values clamp to the minimum frame
    write_reg(CFG_FRAME_WIDTH, 1);
    write_reg(CFG_FRAME_HEIGHT, 1);
    run_frame(2, 2, 2, 0);
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    run_frame(2, 2, 10, 0);
    write_reg(CFG_FRAME_HEIGHT, 8191);

    // Random frames, mostly small
    lim = sent + 1850;
    while (sent < lim) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
      h = $urandom_range(2, 8);
      if (sent > lim - 300) idle_on = 0;
      write_reg(CFG_FRAME_WIDTH, w);
      write_reg(CFG_FRAME_HEIGHT, h);
      if (!held && sent > lim - 1200) begin
        hold_req = 1;
        held = 1;
      end
      run_frame(w, h, 8, $urandom_range(0, 5));
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
